// File: hw/rtl/content_length_deframer_unit_macros.svh
// Assertion helpers for the content-length deframer.
`ifndef CONTENT_LENGTH_DEFRAMER_UNIT_MACROS_SVH
`define CONTENT_LENGTH_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CLD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("deframer check failed");
// Next-cycle implication, checked outside reset.
`define CLD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deframer check failed");
`else
`define CLD_ASSERT_NOW(lbl, pre, post)
`define CLD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: hw/rtl/cld_pkg.sv
package cld_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int REG_BITS    = 32;
  localparam int CMP_BITS    = (LENGTH_BITS > REG_BITS) ? LENGTH_BITS : REG_BITS;
  localparam int PREFIX_LEN  = 16;
  localparam int COL_BITS    = $clog2(PREFIX_LEN + 1);
  localparam int PADDR_BITS  = 3;

  localparam logic [REG_BITS-1:0] MAX_BODY_RESET = 32'd10485760;
  localparam logic REG_MAX_BODY_LENGTH = 1'b0;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Header scanner result for one byte: a valid frame header just closed.
  typedef struct packed {
    logic                   start;
    logic [LENGTH_BITS-1:0] length;
  } hdr_evt_t;

  function automatic logic [7:0] prefix_char(input logic [COL_BITS-2:0] col);
    logic [7:0] ch;
    begin
      case (col)
        4'd0:  ch = 8'h63; // c
        4'd1:  ch = 8'h6f; // o
        4'd2:  ch = 8'h6e; // n
        4'd3:  ch = 8'h74; // t
        4'd4:  ch = 8'h65; // e
        4'd5:  ch = 8'h6e; // n
        4'd6:  ch = 8'h74; // t
        4'd7:  ch = 8'h2d; // -
        4'd8:  ch = 8'h6c; // l
        4'd9:  ch = 8'h65; // e
        4'd10: ch = 8'h6e; // n
        4'd11: ch = 8'h67; // g
        4'd12: ch = 8'h74; // t
        4'd13: ch = 8'h68; // h
        4'd14: ch = 8'h3a; // :
        default: ch = 8'h20;
      endcase
      return ch;
    end
  endfunction

endpackage

// File: hw/rtl/cld_in_if.sv
interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hw/rtl/cld_out_if.sv
interface cld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       last_of_message;
  logic       empty_message;

  modport source (output valid, output body_byte, output last_of_message,
                  output empty_message, input ready);
  modport sink   (input valid, input body_byte, input last_of_message,
                  input empty_message, output ready);
endinterface

// File: hw/rtl/content_length_deframer_unit.sv
// Content-length deframer: takes one stream byte per clock unless the output stalls, and
// passes body bytes of each framed message straight through, flagging the final byte; a
// zero-length message gives a single empty marker. Header bytes, and whole headers whose
// length is missing, malformed, negative, overflowing or above max_body_length, give
// nothing. A byte goes through an input register and then the output register; a stalled
// output holds both. There is no clearing pass after reset.
`include "content_length_deframer_unit_macros.svh"

module content_length_deframer_unit import cld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cld_in_if.sink                stream,
  cld_out_if.source             message,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [REG_BITS-1:0]   pwdata,
  output logic [REG_BITS-1:0]   prdata,
  output logic                  pready
);

  logic [REG_BITS-1:0]    max_len;
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   in_body;
  logic [LENGTH_BITS-1:0] remaining;
  logic                   out_valid;
  logic [7:0]             out_byte;
  logic                   out_last;
  logic                   out_empty;

  logic     out_free;
  logic     advance;
  logic     body_step;
  logic     body_last;
  hdr_evt_t evt;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_BITS-1] == REG_MAX_BODY_LENGTH) ? max_len : '0;

  assign out_free     = !out_valid || message.ready;
  assign advance      = s1_valid && out_free;
  assign stream.ready = !s1_valid || out_free;
  assign body_step    = advance && in_body;
  assign body_last    = (remaining <= LENGTH_BITS'(1));

  cld_hdr u_hdr (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && !in_body),
    .hdr_byte (s1_byte),
    .max_len  (max_len),
    .evt      (evt)
  );

  assign message.valid           = out_valid;
  assign message.body_byte       = out_byte;
  assign message.last_of_message = out_last;
  assign message.empty_message   = out_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= MAX_BODY_RESET;
      s1_valid  <= 1'b0;
      in_body   <= 1'b0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[PADDR_BITS-1] == REG_MAX_BODY_LENGTH))
        max_len <= pwdata;

      if (stream.valid && stream.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (body_step || (evt.start && (evt.length == '0))) begin
        out_valid <= 1'b1;
      end else if (message.ready) begin
        out_valid <= 1'b0;
      end

      if (body_step) begin
        if (body_last) begin
          in_body   <= 1'b0;
          remaining <= '0;
        end else begin
          remaining <= remaining - 1'b1;
        end
      end else if (evt.start && (evt.length != '0)) begin
        // Open the body; a zero length only emits the empty marker.
        in_body   <= 1'b1;
        remaining <= evt.length;
      end
    end
  end

  // Payload registers: s1_byte loads when a byte is taken; the output payload loads only when a result is produced.
  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) s1_byte <= stream.in_byte;
    if (body_step) begin
      out_byte  <= s1_byte;
      out_last  <= body_last;
      out_empty <= 1'b0;
    end else if (evt.start && (evt.length == '0)) begin
      out_byte  <= 8'd0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  `CLD_ASSERT_NOW(a_body_nonzero, in_body, remaining != '0)
  `CLD_ASSERT_NOW(a_empty_shape, out_valid && out_empty, out_last && (out_byte == 8'd0))
  `CLD_ASSERT_NEXT(a_body_closes, body_step && body_last, !in_body && out_valid && out_last)
  `CLD_ASSERT_NOW(a_no_start_in_body, in_body, !evt.start)

endmodule

// File: hw/rtl/cld_hdr.sv
module cld_hdr import cld_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          hdr_byte,
  input  logic [REG_BITS-1:0] max_len,
  output hdr_evt_t            evt
);

  typedef enum logic [1:0] {MODE_PREFIX, MODE_VALUE, MODE_SKIP} line_mode_t;
  typedef enum logic [1:0] {PH_LEAD, PH_MINUS, PH_DIGITS, PH_TRAIL} value_phase_t;

  typedef struct packed {
    logic [1:0]             dprog;
    logic [COL_BITS-1:0]    column;
    line_mode_t             mode;
    logic                   seen;
    value_phase_t           phase;
    logic [LENGTH_BITS-1:0] acc;
    logic                   too_big;
    logic                   neg;
    logic                   bad;
  } hdr_state_t;

  localparam hdr_state_t HDR_CLEAR = '{
    dprog: 2'd0, column: '0, mode: MODE_PREFIX, seen: 1'b0, phase: PH_LEAD,
    acc: '0, too_big: 1'b0, neg: 1'b0, bad: 1'b0};

  hdr_state_t hs;
  hdr_state_t hs_next;

  function automatic hdr_state_t add_digit(input hdr_state_t s, input logic [7:0] c);
    logic [LENGTH_BITS+3:0] prod;
    begin
      prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0}
           + {{LENGTH_BITS{1'b0}}, c[3:0]};
      if (!s.too_big) begin
        if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
          s.acc     = '1;
          s.too_big = 1'b1;
        end else begin
          s.acc = prod[LENGTH_BITS-1:0];
        end
      end
      return s;
    end
  endfunction

  function automatic hdr_state_t value_byte(input hdr_state_t s, input logic [7:0] c);
    logic digit;
    begin
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (!s.bad) begin
        case (s.phase)
          PH_LEAD: begin
            if (c == CHAR_SPACE) begin
              s.phase = PH_LEAD;
            end else if (c == CHAR_MINUS) begin
              s.neg   = 1'b1;
              s.phase = PH_MINUS;
            end else if (digit) begin
              s       = add_digit(s, c);
              s.phase = PH_DIGITS;
            end else begin
              s.bad = 1'b1;
            end
          end
          PH_MINUS: begin
            if (digit) begin
              s       = add_digit(s, c);
              s.phase = PH_DIGITS;
            end else begin
              s.bad = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (digit) begin
              s = add_digit(s, c);
            end else if (c == CHAR_SPACE) begin
              s.phase = PH_TRAIL;
            end else begin
              s.bad = 1'b1;
            end
          end
          default: begin
            if (c != CHAR_SPACE) s.bad = 1'b1;
          end
        endcase
      end
      return s;
    end
  endfunction

  function automatic hdr_state_t content_byte(input hdr_state_t s, input logic [7:0] c);
    logic [7:0] low;
    begin
      low = ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ? c + CASE_DELTA : c;
      case (s.mode)
        MODE_VALUE: s = value_byte(s, c);
        MODE_PREFIX: begin
          if (s.column[COL_BITS-1] || (low != prefix_char(s.column[COL_BITS-2:0]))) begin
            s.mode = MODE_SKIP;
          end else begin
            s.column = s.column + 1'b1;
            if (s.column == COL_BITS'(PREFIX_LEN)) begin
              s.mode = MODE_VALUE;
              s.seen = 1'b1;
            end
          end
        end
        default: s = s;
      endcase
      return s;
    end
  endfunction

  logic pending;
  logic len_ok;
  hdr_state_t after_cr;

  assign pending = (hs.dprog == 2'd1) || (hs.dprog == 2'd3);

  // Header verdict at the final LF of CR LF CR LF.
  assign len_ok = hs.seen && !hs.bad && !hs.too_big && !(hs.neg && (hs.acc != '0))
                && (CMP_BITS'(hs.acc) <= CMP_BITS'(max_len));

  assign after_cr = pending ? content_byte(hs, CHAR_CR) : hs;

  always_comb begin
    hs_next    = hs;
    evt.start  = 1'b0;
    evt.length = hs.acc;
    if (step) begin
      if ((hdr_byte == CHAR_LF) && pending) begin
        if (hs.dprog == 2'd3) begin
          evt.start = len_ok;
          hs_next   = HDR_CLEAR;
        end else begin
          hs_next.dprog = 2'd2;
          if ((hs.mode == MODE_VALUE) && (hs.phase != PH_DIGITS) && (hs.phase != PH_TRAIL))
            hs_next.bad = 1'b1;
          hs_next.column = '0;
          hs_next.mode   = hs.seen ? MODE_SKIP : MODE_PREFIX;
        end
      end else if (hdr_byte == CHAR_CR) begin
        hs_next       = after_cr;
        hs_next.dprog = (hs.dprog == 2'd2) ? 2'd3 : 2'd1;
      end else begin
        hs_next       = content_byte(after_cr, hdr_byte);
        hs_next.dprog = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs <= HDR_CLEAR;
    end else begin
      hs <= hs_next;
    end
  end

endmodule
